// ----- design/btxp_pkg.sv -----
// Shared types and codes for the transaction byte parser.
package btxp_pkg;

  // parse phase codes
  localparam logic [3:0] PH_VERSION    = 4'd0;
  localparam logic [3:0] PH_IN_COUNT   = 4'd1;
  localparam logic [3:0] PH_HASH       = 4'd2;
  localparam logic [3:0] PH_PREV_INDEX = 4'd3;
  localparam logic [3:0] PH_IN_SLEN    = 4'd4;
  localparam logic [3:0] PH_IN_SCRIPT  = 4'd5;
  localparam logic [3:0] PH_SEQUENCE   = 4'd6;
  localparam logic [3:0] PH_OUT_COUNT  = 4'd7;
  localparam logic [3:0] PH_AMOUNT     = 4'd8;
  localparam logic [3:0] PH_OUT_SLEN   = 4'd9;
  localparam logic [3:0] PH_OUT_SCRIPT = 4'd10;
  localparam logic [3:0] PH_LOCKTIME   = 4'd11;
  localparam logic [3:0] PH_DONE       = 4'd12;

  // result kinds
  localparam logic [3:0] KIND_VERSION    = 4'd0;
  localparam logic [3:0] KIND_IN_COUNT   = 4'd1;
  localparam logic [3:0] KIND_HASH_BYTE  = 4'd2;
  localparam logic [3:0] KIND_PREV_INDEX = 4'd3;
  localparam logic [3:0] KIND_IN_SLEN    = 4'd4;
  localparam logic [3:0] KIND_IN_SCRIPT  = 4'd5;
  localparam logic [3:0] KIND_SEQUENCE   = 4'd6;
  localparam logic [3:0] KIND_OUT_COUNT  = 4'd7;
  localparam logic [3:0] KIND_AMOUNT     = 4'd8;
  localparam logic [3:0] KIND_OUT_SLEN   = 4'd9;
  localparam logic [3:0] KIND_OUT_SCRIPT = 4'd10;
  localparam logic [3:0] KIND_LOCKTIME   = 4'd11;
  localparam logic [3:0] KIND_STATUS     = 4'd12;

  // buffer status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TRUNCATED   = 3'd1;
  localparam logic [2:0] ST_NO_INPUTS   = 3'd2;
  localparam logic [2:0] ST_TOO_MANY    = 3'd3;
  localparam logic [2:0] ST_SCRIPT_LONG = 3'd4;

  localparam logic [15:0] SCRIPT_LEN_RESET = 16'd10000;
  localparam logic [15:0] HASH_BYTES       = 16'd32;
  localparam logic [15:0] WORD4_BYTES      = 16'd4;
  localparam logic [15:0] WORD8_BYTES      = 16'd8;

  localparam logic [7:0] CS_PREFIX_16 = 8'hFD;
  localparam logic [7:0] CS_PREFIX_32 = 8'hFE;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [7:0]  entry;
    logic [15:0] offset;
    logic [2:0]  status;
    logic        eot;
  } result_t;

endpackage

// ----- design/bitcoin_tx_byte_parser.sv -----
// Streaming parser for serialized legacy transactions, one byte per transfer.
//
// The parser takes one byte per cycle while in_ready is high. Each byte updates
// the phase machine and field accumulator and writes zero, one or two results
// into a four-entry output queue, which drains one result per cycle while
// out_ready is high. The input is ready while the queue has at least two free
// slots, so a stalled output does not block input until fewer than two slots
// are free; a buffer's last byte that also completes a field yields two
// results. Each result is registered in the queue before it reaches the output.
module bitcoin_tx_byte_parser #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  field_kind,
  output logic [63:0] field_value,
  output logic [7:0]  entry_number,
  output logic [15:0] byte_offset,
  output logic [2:0]  parse_status,
  output logic        end_of_tx
);
  import btxp_pkg::*;

  localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [63:0] MAX_ENT = 64'(MAX_ENTRIES);

  logic [15:0]        max_script_len;
  logic [3:0]         phase, phase_next;
  logic [63:0]        accum, accum_next;
  logic [15:0]        bif, bif_next;
  logic [3:0]         need, need_next;
  logic [ENTRY_W-1:0] total, total_next;
  logic [ENTRY_W-1:0] counter, counter_next;
  logic [15:0]        remain, remain_next;
  logic               err, err_next;
  logic               zero_in, zero_in_next;

  // output queue
  result_t     queue [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count, count_next;

  logic        in_fire, out_fire;
  logic [63:0] acc_or;
  logic [15:0] bif_inc;
  logic        v_done;
  logic [63:0] v_val, v_accum;
  logic [15:0] v_bif;
  logic [3:0]  v_need, need_dec;
  logic [ENTRY_W:0] cnt_inc;
  logic [15:0] remain_dec;
  logic        emit;
  result_t     fres, sres, slot0;
  logic [1:0]  push_cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count <= 3'd2);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = (count != 3'd0);
  assign out_fire  = out_valid & out_ready;

  assign field_kind   = queue[rd_ptr].kind;
  assign field_value  = queue[rd_ptr].value;
  assign entry_number = queue[rd_ptr].entry;
  assign byte_offset  = queue[rd_ptr].offset;
  assign parse_status = queue[rd_ptr].status;
  assign end_of_tx    = queue[rd_ptr].eot;

  // shared field helpers
  assign acc_or     = accum | (64'(data_byte) << {bif[2:0], 3'b000});
  assign bif_inc    = bif + 16'd1;
  assign need_dec   = need - 4'd1;
  assign cnt_inc    = {1'b0, counter} + {{ENTRY_W{1'b0}}, 1'b1};
  assign remain_dec = remain - 16'd1;

  // compact-size decode step
  always_comb begin
    v_done  = 1'b0;
    v_val   = acc_or;
    v_accum = accum;
    v_bif   = bif;
    v_need  = need;
    if (need == 4'd0) begin
      if (data_byte < CS_PREFIX_16) begin
        v_done = 1'b1;
        v_val  = 64'(data_byte);
      end else begin
        v_need  = (data_byte == CS_PREFIX_16) ? 4'd2 :
                  (data_byte == CS_PREFIX_32) ? 4'd4 : 4'd8;
        v_accum = '0;
        v_bif   = '0;
      end
    end else if (need_dec == 4'd0) begin
      v_done  = 1'b1;
      v_need  = 4'd0;
      v_accum = '0;
      v_bif   = '0;
    end else begin
      v_need  = need_dec;
      v_accum = acc_or;
      v_bif   = bif_inc;
    end
  end

  always_comb begin
    phase_next   = phase;
    accum_next   = accum;
    bif_next     = bif;
    need_next    = need;
    total_next   = total;
    counter_next = counter;
    remain_next  = remain;
    err_next     = err;
    zero_in_next = zero_in;
    emit         = 1'b0;
    fres.kind    = KIND_VERSION;
    fres.value   = '0;
    fres.entry   = 8'(counter);
    fres.offset  = '0;
    fres.status  = ST_OK;
    fres.eot     = 1'b0;
    if (!err) begin
      case (phase)
        PH_VERSION, PH_PREV_INDEX, PH_SEQUENCE, PH_LOCKTIME, PH_AMOUNT: begin
          if (bif_inc >= ((phase == PH_AMOUNT) ? WORD8_BYTES : WORD4_BYTES)) begin
            emit       = 1'b1;
            fres.value = acc_or;
            accum_next = '0;
            bif_next   = '0;
            case (phase)
              PH_VERSION: begin
                fres.kind  = KIND_VERSION;
                fres.entry = '0;
                phase_next = PH_IN_COUNT;
              end
              PH_PREV_INDEX: begin
                fres.kind  = KIND_PREV_INDEX;
                phase_next = PH_IN_SLEN;
              end
              PH_SEQUENCE: begin
                fres.kind    = KIND_SEQUENCE;
                counter_next = cnt_inc[ENTRY_W-1:0];
                phase_next   = (cnt_inc >= {1'b0, total}) ? PH_OUT_COUNT : PH_HASH;
              end
              PH_AMOUNT: begin
                fres.kind  = KIND_AMOUNT;
                phase_next = PH_OUT_SLEN;
              end
              default: begin
                fres.kind  = KIND_LOCKTIME;
                fres.entry = '0;
                phase_next = PH_DONE;
              end
            endcase
          end else begin
            accum_next = acc_or;
            bif_next   = bif_inc;
          end
        end
        PH_IN_COUNT, PH_OUT_COUNT: begin
          accum_next = v_accum;
          bif_next   = v_bif;
          need_next  = v_need;
          if (v_done) begin
            emit       = 1'b1;
            fres.kind  = (phase == PH_IN_COUNT) ? KIND_IN_COUNT : KIND_OUT_COUNT;
            fres.value = v_val;
            fres.entry = '0;
            if (v_val > MAX_ENT) begin
              err_next = 1'b1;
            end else begin
              total_next   = v_val[ENTRY_W-1:0];
              counter_next = '0;
              if (phase == PH_IN_COUNT) begin
                zero_in_next = (v_val == 64'd0);
                phase_next   = (v_val == 64'd0) ? PH_OUT_COUNT : PH_HASH;
              end else begin
                phase_next = (v_val == 64'd0) ? PH_LOCKTIME : PH_AMOUNT;
              end
            end
          end
        end
        PH_IN_SLEN, PH_OUT_SLEN: begin
          accum_next = v_accum;
          bif_next   = v_bif;
          need_next  = v_need;
          if (v_done) begin
            emit       = 1'b1;
            fres.kind  = (phase == PH_IN_SLEN) ? KIND_IN_SLEN : KIND_OUT_SLEN;
            fres.value = v_val;
            if (v_val > 64'(max_script_len)) begin
              err_next = 1'b1;
            end else begin
              remain_next = v_val[15:0];
              bif_next    = '0;
              if (phase == PH_IN_SLEN) begin
                phase_next = (v_val == 64'd0) ? PH_SEQUENCE : PH_IN_SCRIPT;
              end else if (v_val != 64'd0) begin
                phase_next = PH_OUT_SCRIPT;
              end else begin
                counter_next = cnt_inc[ENTRY_W-1:0];
                phase_next   = (cnt_inc >= {1'b0, total}) ? PH_LOCKTIME : PH_AMOUNT;
              end
            end
          end
        end
        PH_HASH: begin
          emit        = 1'b1;
          fres.kind   = KIND_HASH_BYTE;
          fres.value  = 64'(data_byte);
          fres.offset = bif;
          if (bif_inc >= HASH_BYTES) begin
            bif_next   = '0;
            phase_next = PH_PREV_INDEX;
          end else begin
            bif_next = bif_inc;
          end
        end
        PH_IN_SCRIPT, PH_OUT_SCRIPT: begin
          emit        = 1'b1;
          fres.kind   = (phase == PH_IN_SCRIPT) ? KIND_IN_SCRIPT : KIND_OUT_SCRIPT;
          fres.value  = 64'(data_byte);
          fres.offset = bif;
          bif_next    = bif_inc;
          remain_next = remain_dec;
          if (remain_dec == 16'd0) begin
            bif_next = '0;
            if (phase == PH_IN_SCRIPT) begin
              phase_next = PH_SEQUENCE;
            end else begin
              counter_next = cnt_inc[ENTRY_W-1:0];
              phase_next   = (cnt_inc >= {1'b0, total}) ? PH_LOCKTIME : PH_AMOUNT;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // status reflects the state left by this byte
    sres.kind   = KIND_STATUS;
    sres.value  = '0;
    sres.entry  = '0;
    sres.offset = '0;
    sres.eot    = 1'b1;
    if (err_next) begin
      sres.status = (phase_next == PH_IN_COUNT || phase_next == PH_OUT_COUNT) ?
                    ST_TOO_MANY : ST_SCRIPT_LONG;
    end else if (zero_in_next) begin
      sres.status = ST_NO_INPUTS;
    end else if (phase_next != PH_DONE) begin
      sres.status = ST_TRUNCATED;
    end else begin
      sres.status = ST_OK;
    end

    // start over for the next buffer
    if (last_byte) begin
      phase_next   = PH_VERSION;
      accum_next   = '0;
      bif_next     = '0;
      need_next    = '0;
      total_next   = '0;
      counter_next = '0;
      remain_next  = '0;
      err_next     = 1'b0;
      zero_in_next = 1'b0;
    end
  end

  assign slot0    = emit ? fres : sres;
  assign push_cnt = in_fire ? ({1'b0, emit} + {1'b0, last_byte}) : 2'd0;
  assign count_next = count + 3'(push_cnt) - {2'b00, out_fire};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_script_len <= SCRIPT_LEN_RESET;
      phase          <= PH_VERSION;
      accum          <= '0;
      bif            <= '0;
      need           <= '0;
      total          <= '0;
      counter        <= '0;
      remain         <= '0;
      err            <= 1'b0;
      zero_in        <= 1'b0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (cfg_valid) begin
        max_script_len <= cfg_data;
      end
      if (in_fire) begin
        phase   <= phase_next;
        accum   <= accum_next;
        bif     <= bif_next;
        need    <= need_next;
        total   <= total_next;
        counter <= counter_next;
        remain  <= remain_next;
        err     <= err_next;
        zero_in <= zero_in_next;
      end
      wr_ptr <= wr_ptr + push_cnt;
      if (out_fire) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (push_cnt == 2'd2) begin
      queue[wr_ptr + 2'd1] <= sres;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the transaction byte parser: random buffers against a scoreboard.
module tb;
  import btxp_pkg::*;

  localparam logic [7:0] CS_PREFIX_64 = 8'hFF;
  localparam int unsigned ITEM_TARGET = 1300;
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned ENTRY_LIMIT = 256;

  class tx_parse_scoreboard;
    logic [15:0] max_slen;
    logic [3:0]  phase;
    logic [63:0] accum;
    logic [15:0] nbytes;
    logic [3:0]  need;
    int unsigned total;
    int unsigned counter;
    logic [15:0] remaining;
    bit          hold;
    bit          zero_in;
    result_t     expected_q[$];
    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned status_seen[5];

    function new();
      max_slen = SCRIPT_LEN_RESET;
      n_fail = 0;
      n_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = PH_VERSION;
      accum = '0;
      nbytes = '0;
      need = '0;
      total = 0;
      counter = 0;
      remaining = '0;
      hold = 1'b0;
      zero_in = 1'b0;
    endfunction

    function void set_max_slen(input logic [15:0] v);
      max_slen = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(input logic [3:0] kind, input logic [63:0] value,
                       input int unsigned entry, input logic [15:0] offset,
                       input logic [2:0] status, input logic eot);
      result_t r;
      r.kind = kind;
      r.value = value;
      r.entry = 8'(entry);
      r.offset = offset;
      r.status = status;
      r.eot = eot;
      expected_q.push_back(r);
    endfunction

    // little-endian fixed-size field; 1 when the field completes
    function bit take_fixed(input logic [7:0] b, input logic [15:0] size,
                            output logic [63:0] value);
      accum = accum | ({56'd0, b} << (8 * nbytes[2:0]));
      nbytes++;
      if (nbytes >= size) begin
        value = accum;
        accum = '0;
        nbytes = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit take_compact(input logic [7:0] b, output logic [63:0] value);
      if (need == 0) begin
        if (b < CS_PREFIX_16) begin
          value = {56'd0, b};
          return 1'b1;
        end
        need = (b == CS_PREFIX_16) ? 4'd2 : (b == CS_PREFIX_32) ? 4'd4 : 4'd8;
        accum = '0;
        nbytes = '0;
        return 1'b0;
      end
      accum = accum | ({56'd0, b} << (8 * nbytes[2:0]));
      nbytes++;
      need--;
      if (need == 0) begin
        value = accum;
        accum = '0;
        nbytes = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void next_output();
      counter++;
      phase = (counter >= total) ? PH_LOCKTIME : PH_AMOUNT;
    endfunction

    function void parse_byte(input logic [7:0] b);
      logic [63:0] v;
      int unsigned e;
      v = '0;
      e = counter;
      if (hold) return;
      case (phase)
        PH_VERSION: if (take_fixed(b, WORD4_BYTES, v)) begin
          push(KIND_VERSION, v, 0, 0, ST_OK, 1'b0);
          phase = PH_IN_COUNT;
        end
        PH_IN_COUNT: if (take_compact(b, v)) begin
          push(KIND_IN_COUNT, v, 0, 0, ST_OK, 1'b0);
          if (v > ENTRY_LIMIT) hold = 1'b1;
          else begin
            total = v[31:0];
            counter = 0;
            zero_in = (v == 0);
            phase = (v == 0) ? PH_OUT_COUNT : PH_HASH;
          end
        end
        PH_HASH: begin
          push(KIND_HASH_BYTE, b, e, nbytes, ST_OK, 1'b0);
          nbytes++;
          if (nbytes >= HASH_BYTES) begin
            nbytes = '0;
            phase = PH_PREV_INDEX;
          end
        end
        PH_PREV_INDEX: if (take_fixed(b, WORD4_BYTES, v)) begin
          push(KIND_PREV_INDEX, v, e, 0, ST_OK, 1'b0);
          phase = PH_IN_SLEN;
        end
        PH_IN_SLEN: if (take_compact(b, v)) begin
          push(KIND_IN_SLEN, v, e, 0, ST_OK, 1'b0);
          if (v > max_slen) hold = 1'b1;
          else begin
            remaining = v[15:0];
            nbytes = '0;
            phase = (v == 0) ? PH_SEQUENCE : PH_IN_SCRIPT;
          end
        end
        PH_IN_SCRIPT: begin
          push(KIND_IN_SCRIPT, b, e, nbytes, ST_OK, 1'b0);
          nbytes++;
          remaining--;
          if (remaining == 0) begin
            nbytes = '0;
            phase = PH_SEQUENCE;
          end
        end
        PH_SEQUENCE: if (take_fixed(b, WORD4_BYTES, v)) begin
          push(KIND_SEQUENCE, v, e, 0, ST_OK, 1'b0);
          counter++;
          phase = (counter >= total) ? PH_OUT_COUNT : PH_HASH;
        end
        PH_OUT_COUNT: if (take_compact(b, v)) begin
          push(KIND_OUT_COUNT, v, 0, 0, ST_OK, 1'b0);
          if (v > ENTRY_LIMIT) hold = 1'b1;
          else begin
            total = v[31:0];
            counter = 0;
            phase = (v == 0) ? PH_LOCKTIME : PH_AMOUNT;
          end
        end
        PH_AMOUNT: if (take_fixed(b, WORD8_BYTES, v)) begin
          push(KIND_AMOUNT, v, e, 0, ST_OK, 1'b0);
          phase = PH_OUT_SLEN;
        end
        PH_OUT_SLEN: if (take_compact(b, v)) begin
          push(KIND_OUT_SLEN, v, e, 0, ST_OK, 1'b0);
          if (v > max_slen) hold = 1'b1;
          else begin
            remaining = v[15:0];
            nbytes = '0;
            if (v == 0) next_output();
            else phase = PH_OUT_SCRIPT;
          end
        end
        PH_OUT_SCRIPT: begin
          push(KIND_OUT_SCRIPT, b, e, nbytes, ST_OK, 1'b0);
          nbytes++;
          remaining--;
          if (remaining == 0) begin
            nbytes = '0;
            next_output();
          end
        end
        PH_LOCKTIME: if (take_fixed(b, WORD4_BYTES, v)) begin
          push(KIND_LOCKTIME, v, 0, 0, ST_OK, 1'b0);
          phase = PH_DONE;
        end
        default: ;
      endcase
    endfunction

    // returns 1 when the byte was actually parsed rather than ignored
    function bit note_byte(input logic [7:0] b, input logic last);
      bit used;
      logic [2:0] st;
      used = !hold && phase != PH_DONE;
      parse_byte(b);
      if (last) begin
        if (hold) st = (phase == PH_IN_COUNT || phase == PH_OUT_COUNT) ? ST_TOO_MANY
                                                                      : ST_SCRIPT_LONG;
        else if (zero_in) st = ST_NO_INPUTS;
        else if (phase != PH_DONE) st = ST_TRUNCATED;
        else st = ST_OK;
        push(KIND_STATUS, '0, 0, 0, st, 1'b1);
        status_seen[st]++;
        clear_parse();
      end
      return used;
    endfunction

    function void check_result(input result_t got);
      result_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: field_kind %0d field_value %0h", got.kind, got.value);
        n_fail++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("field_kind: expected %0d, got %0d", want.kind, got.kind);
        n_fail++;
      end
      if (got.value !== want.value) begin
        $error("field_value: expected %0h, got %0h", want.value, got.value);
        n_fail++;
      end
      if (got.entry !== want.entry) begin
        $error("entry_number: expected %0d, got %0d", want.entry, got.entry);
        n_fail++;
      end
      if (got.offset !== want.offset) begin
        $error("byte_offset: expected %0d, got %0d", want.offset, got.offset);
        n_fail++;
      end
      if (got.status !== want.status) begin
        $error("parse_status: expected %0d, got %0d", want.status, got.status);
        n_fail++;
      end
      if (got.eot !== want.eot) begin
        $error("end_of_tx: expected %0d, got %0d", want.eot, got.eot);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  field_kind;
  logic [63:0] field_value;
  logic [7:0]  entry_number;
  logic [15:0] byte_offset;
  logic [2:0]  parse_status;
  logic        end_of_tx;

  tx_parse_scoreboard sb;
  logic [7:0]  tx_q[$];
  bit          calm;
  bit          quiet;
  int unsigned bytes_used;
  int unsigned bytes_sent;
  int unsigned buffers_sent;

  bitcoin_tx_byte_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .field_kind   (field_kind),
    .field_value  (field_value),
    .entry_number (entry_number),
    .byte_offset  (byte_offset),
    .parse_status (parse_status),
    .end_of_tx    (end_of_tx)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_600_000;
    $display("tb: errors");
    $finish;
  end

  // result side: random stall bursts, none once quiet
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({field_kind, field_value, entry_number, byte_offset, parse_status, end_of_tx});
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_valid = 1'b1;
    data_byte = b;
    last_byte = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_byte(b, last)) bytes_used++;
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic pause_input(input int unsigned n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // hold input until every predicted result has been seen
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_buffer(input bit hold_mid);
    int unsigned i;
    for (i = 0; i < tx_q.size(); i++) begin
      if (hold_mid && i == tx_q.size() / 2) drain();
      send_byte(tx_q[i], i == tx_q.size() - 1);
      if (!quiet && !calm && $urandom_range(0, 99) < 15) pause_input($urandom_range(1, 10));
    end
    buffers_sent++;
    tx_q.delete();
  endtask

  task automatic write_max_slen(input logic [15:0] v);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_max_slen(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic put_le(input logic [63:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) tx_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_random(input int unsigned n);
    repeat (n) tx_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // mostly the shortest encoding, now and then one size up
  task automatic put_compact(input logic [63:0] v);
    int unsigned form;
    form = (v < CS_PREFIX_16) ? 0 : (v <= 64'hFFFF) ? 1 : (v <= 64'hFFFF_FFFF) ? 2 : 3;
    if (form < 3 && $urandom_range(0, 7) == 0) form++;
    case (form)
      0: tx_q.push_back(v[7:0]);
      1: begin
        tx_q.push_back(CS_PREFIX_16);
        put_le(v, 2);
      end
      2: begin
        tx_q.push_back(CS_PREFIX_32);
        put_le(v, 4);
      end
      default: begin
        tx_q.push_back(CS_PREFIX_64);
        put_le(v, 8);
      end
    endcase
  endtask

  function automatic logic [63:0] pick_slen(input bit empty);
    int unsigned r;
    if (empty) return '0;
    r = $urandom_range(0, 15);
    if (r == 0) return {48'd0, sb.max_slen} + 64'd1;
    if (r == 1) return {48'd0, sb.max_slen};
    return $urandom_range(0, (sb.max_slen < 16'd12) ? sb.max_slen : 12);
  endfunction

  // stop is set when the buffer must end here: overlong or too large to spell out
  task automatic put_script(input logic [63:0] len, output bit stop);
    put_compact(len);
    stop = 1'b1;
    if (len > sb.max_slen) put_random($urandom_range(0, 3));
    else if (len > 64) put_random(3);
    else begin
      put_random(32'(len));
      stop = 1'b0;
    end
  endtask

  task automatic put_over_count();
    logic [63:0] v;
    case ($urandom_range(0, 2))
      0: v = ENTRY_LIMIT + 1;
      1: v = $urandom_range(ENTRY_LIMIT + 1, 65535);
      default: v = {$urandom, $urandom} | 64'h1_0000_0000;
    endcase
    put_compact(v);
    put_random($urandom_range(0, 3));
  endtask

  // bad_count: 0 none, 1 input count over the limit, 2 output count over the limit
  task automatic build_tx(input int unsigned bad_count, input int unsigned wide_outs);
    int unsigned n_in;
    int unsigned n_out;
    bit stop;
    put_le($urandom, 4);
    if (bad_count == 1) begin
      put_over_count();
      return;
    end
    n_in = (wide_outs != 0) ? 1 : ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    put_compact(n_in);
    repeat (n_in) begin
      put_random(32);
      put_le($urandom, 4);
      put_script(pick_slen(wide_outs != 0), stop);
      if (stop) return;
      put_le($urandom, 4);
    end
    if (bad_count == 2) begin
      put_over_count();
      return;
    end
    n_out = (wide_outs != 0) ? wide_outs : $urandom_range(0, 3);
    put_compact(n_out);
    repeat (n_out) begin
      put_le({$urandom, $urandom}, 8);
      put_script(pick_slen(wide_outs != 0), stop);
      if (stop) return;
    end
    put_le($urandom, 4);
  endtask

  task automatic make_random_buffer();
    int unsigned r;
    int unsigned keep;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      build_tx(0, 0);
      if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 4));
    end else if (r < 75) begin
      build_tx(0, 0);
      keep = $urandom_range(1, tx_q.size());
      while (tx_q.size() > keep) void'(tx_q.pop_back());
    end else if (r < 88) begin
      build_tx($urandom_range(1, 2), 0);
    end else begin
      put_random($urandom_range(1, 40));
    end
  endtask

  initial begin
    logic [15:0] slen_plan[N_PHASES];
    int unsigned budget;
    bit phase_start;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    calm = 1'b0;
    quiet = 1'b0;
    bytes_used = 0;
    bytes_sent = 0;
    buffers_sent = 0;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero inputs and outputs; last byte closes the lock time as well
    put_le(64'hFFFF_FFFF, 4);
    tx_q.push_back(8'h00);
    tx_q.push_back(8'h00);
    put_le('0, 4);
    send_buffer(1'b0);
    // input count just over the limit, trailing byte dropped
    put_le('0, 4);
    tx_q.push_back(CS_PREFIX_16);
    put_le(ENTRY_LIMIT + 1, 2);
    tx_q.push_back(8'hAB);
    send_buffer(1'b0);
    // lone byte
    tx_q.push_back(8'h00);
    send_buffer(1'b0);

    slen_plan = '{SCRIPT_LEN_RESET, 16'd0, 16'hFFFF, 16'd6, SCRIPT_LEN_RESET,
                  16'($urandom_range(7, 64))};
    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        drain();
        write_max_slen(slen_plan[p]);
      end
      quiet = (p == N_PHASES - 1);
      if (p == 4) begin
        // output count right at the entry limit, cut short after the first outputs
        build_tx(0, ENTRY_LIMIT);
        while (tx_q.size() > 200) void'(tx_q.pop_back());
        send_buffer(1'b0);
      end
      budget = ITEM_TARGET * (p + 1) / N_PHASES;
      phase_start = 1'b1;
      while (bytes_sent < budget) begin
        calm = ($urandom_range(0, 3) == 0);
        make_random_buffer();
        send_buffer(!quiet && (phase_start || $urandom_range(0, 29) == 0));
        phase_start = 1'b0;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("summary: %0d buffers, %0d bytes parsed, %0d results compared, six script limits",
             buffers_sent, bytes_used, sb.n_checked);
    $display("summary: ok %0d, truncated %0d, no inputs %0d, too many %0d, script long %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_TRUNCATED], sb.status_seen[ST_NO_INPUTS],
             sb.status_seen[ST_TOO_MANY], sb.status_seen[ST_SCRIPT_LONG]);
    if (sb.n_fail == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end
endmodule
